// ----- design/transfer_function_lut_interpolator_macros.svh -----
// assertion macros shared by the transfer function table modules
`ifndef TRANSFER_FUNCTION_LUT_INTERPOLATOR_MACROS_SVH
`define TRANSFER_FUNCTION_LUT_INTERPOLATOR_MACROS_SVH

// same-cycle implication, checked on clk and idle during rst
`define TFL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk and idle during rst
`define TFL_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/tfl_pkg.sv -----
// shared types, codes and helpers of the transfer function table block
package tfl_pkg;

  typedef enum logic [1:0] {
    ACT_LOAD_COLOR   = 2'd0,
    ACT_LOAD_OPACITY = 2'd1,
    ACT_REQUEST      = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    KIND_COLOR,
    KIND_OPACITY,
    KIND_REQUEST
  } kind_t;

  typedef enum logic [0:0] {
    CFG_COLOR_COUNT   = 1'b0,
    CFG_OPACITY_COUNT = 1'b1
  } cfg_reg_t;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [1:0]  action;
    logic [5:0]  knot_index;
    logic [15:0] knot_red;
    logic [15:0] knot_green;
    logic [15:0] knot_blue;
    logic [15:0] knot_alpha;
    logic [15:0] knot_opacity;
    logic [9:0]  entry_index;
  } item_t;

  typedef struct packed {
    logic [9:0]  entry_number;
    logic [15:0] out_red;
    logic [15:0] out_green;
    logic [15:0] out_blue;
    logic [15:0] out_alpha;
  } result_t;

  // classified transaction handed from the front end to the back end
  typedef struct packed {
    kind_t       kind;
    logic [5:0]  knot_index;
    logic [63:0] color;       // alpha, blue, green, red from msb down
    logic [15:0] opacity;
    logic [9:0]  entry;
    logic        color_ok;
    logic        opacity_ok;
  } queue_item_t;

  function automatic logic [8:0] clamp_count(input logic [6:0] n, input int unsigned max_k);
    logic [8:0] lim;
    lim = 9'(max_k);
    if ({2'b00, n} > lim) return lim;
    return {2'b00, n};
  endfunction

endpackage

// ----- design/transfer_function_lut_interpolator.sv -----
// Piecewise-linear transfer function table. Colour and opacity knots are loaded
// through the item channel; a request returns one RGBA table entry interpolated
// between the two knots of its segment. The block takes one transaction per cycle
// and returns one result per cycle for a stream of requests while results are not
// stalled. The back end holds two pipelined dividers (segment bounds, interpolation
// step) that produce one quotient bit per stage, the segment index itself coming
// from a one-stage reciprocal multiply. A stalled result holds the whole back end;
// a four-deep queue lets the front keep taking transactions meanwhile. The user
// must write knot counts on the configuration channel only while no transaction is
// in flight; the block itself does not enforce this.
module transfer_function_lut_interpolator import tfl_pkg::*; #(
  parameter int TABLE_SIZE = 1024,
  parameter int MAX_KNOTS  = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [0:0] cfg_index,
  input  logic [6:0] cfg_data,
  input  logic       item_valid,
  output logic       item_ready,
  input  item_t      item,
  output logic       result_valid,
  input  logic       result_ready,
  output result_t    result
);
  logic [6:0]  color_knot_count;
  logic [6:0]  opacity_knot_count;
  logic        push_valid;
  logic        push_ready;
  queue_item_t push_item;
  logic        pop_valid;
  logic        pop_ready;
  queue_item_t pop_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_knot_count   <= '0;
      opacity_knot_count <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_COLOR_COUNT:   color_knot_count   <= cfg_data;
        CFG_OPACITY_COUNT: opacity_knot_count <= cfg_data;
        default: ;
      endcase
    end
  end

  tfl_front #(
    .TABLE_SIZE(TABLE_SIZE), .MAX_KNOTS(MAX_KNOTS)
  ) u_front (
    .clk                (clk),
    .rst                (rst),
    .item_valid         (item_valid),
    .item_ready         (item_ready),
    .item               (item),
    .color_knot_count   (color_knot_count),
    .opacity_knot_count (opacity_knot_count),
    .push_valid         (push_valid),
    .push_ready         (push_ready),
    .push_item          (push_item)
  );

  tfl_fifo u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  tfl_back #(
    .TABLE_SIZE(TABLE_SIZE), .MAX_KNOTS(MAX_KNOTS)
  ) u_back (
    .clk                (clk),
    .rst                (rst),
    .pop_valid          (pop_valid),
    .pop_ready          (pop_ready),
    .pop_item           (pop_item),
    .color_knot_count   (color_knot_count),
    .opacity_knot_count (opacity_knot_count),
    .result_valid       (result_valid),
    .result_ready       (result_ready),
    .result             (result)
  );

endmodule

// ----- design/tfl_fifo.sv -----
// short queue between the classifying front end and the interpolation back end
`include "transfer_function_lut_interpolator_macros.svh"

module tfl_fifo import tfl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push_valid,
  output logic        push_ready,
  input  queue_item_t push_item,
  output logic        pop_valid,
  input  logic        pop_ready,
  output queue_item_t pop_item
);
  localparam int PTW = $clog2(QUEUE_DEPTH);
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);

  queue_item_t      slots [QUEUE_DEPTH];
  logic [PTW-1:0]   wr_ptr;
  logic [PTW-1:0]   rd_ptr;
  logic [CW-1:0]    count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CW'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PTW'(1);
      if (pop) rd_ptr <= rd_ptr + PTW'(1);
      count <= count + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

  `TFL_ASSERT_IMP(a_queue_bound, 1'b1, count <= CW'(QUEUE_DEPTH), "queue count beyond depth")
  `TFL_ASSERT_NXT(a_queue_fill, push && !pop, count == $past(count) + CW'(1), "queue fill lost")
  `TFL_ASSERT_NXT(a_queue_drain, pop && !push, count == $past(count) - CW'(1), "queue drain lost")

endmodule

// ----- design/tfl_front.sv -----
// front end: takes transactions, drops the ones without effect, flags requests
module tfl_front import tfl_pkg::*; #(
  parameter int TABLE_SIZE = 1024,
  parameter int MAX_KNOTS  = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  item_t       item,
  input  logic [6:0]  color_knot_count,
  input  logic [6:0]  opacity_knot_count,
  output logic        push_valid,
  input  logic        push_ready,
  output queue_item_t push_item
);
  logic        fr_valid;
  queue_item_t fr_item;
  queue_item_t cls_item;
  logic        cls_keep;
  logic [8:0]  nc;
  logic [8:0]  no;
  logic        in_range;

  assign nc       = clamp_count(color_knot_count, MAX_KNOTS);
  assign no       = clamp_count(opacity_knot_count, MAX_KNOTS);
  assign in_range = int'(item.entry_index) < TABLE_SIZE;

  always_comb begin
    cls_item.kind       = KIND_REQUEST;
    cls_item.knot_index = item.knot_index;
    cls_item.color      = {item.knot_alpha, item.knot_blue, item.knot_green, item.knot_red};
    cls_item.opacity    = item.knot_opacity;
    cls_item.entry      = item.entry_index;
    cls_item.color_ok   = (nc >= 9'd2) && in_range;
    cls_item.opacity_ok = (no >= 9'd2) && in_range;
    cls_keep            = 1'b0;
    unique case (item.action)
      ACT_LOAD_COLOR: begin
        cls_item.kind = KIND_COLOR;
        cls_keep      = int'(item.knot_index) < MAX_KNOTS;
      end
      ACT_LOAD_OPACITY: begin
        cls_item.kind = KIND_OPACITY;
        cls_keep      = int'(item.knot_index) < MAX_KNOTS;
      end
      ACT_REQUEST: begin
        cls_keep = 1'b1;
      end
      default: cls_keep = 1'b0;
    endcase
  end

  assign item_ready = !fr_valid || push_ready;
  assign push_valid = fr_valid;
  assign push_item  = fr_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
    end else if (item_ready) begin
      fr_valid <= item_valid && cls_keep;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready) fr_item <= cls_item;
  end

endmodule

// ----- design/tfl_div.sv -----
// pipelined restoring divider, one quotient bit per stage, lanes share control
module tfl_div #(
  parameter int NW    = 8,
  parameter int DW    = 8,
  parameter int LANES = 1,
  parameter int SW    = 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [LANES-1:0][NW-1:0]  num,
  input  logic [LANES-1:0][DW-1:0]  den,
  input  logic [SW-1:0]             side_in,
  output logic                      out_valid,
  output logic [LANES-1:0][NW-1:0]  quot,
  output logic [SW-1:0]             side_out
);
  logic [LANES-1:0][NW-1:0] r_num  [NW];
  logic [LANES-1:0][NW-1:0] r_quot [NW];
  logic [LANES-1:0][DW-1:0] r_rem  [NW];
  logic [LANES-1:0][DW-1:0] r_den  [NW];
  logic [SW-1:0]            r_side [NW];
  logic                     r_valid [NW];

  for (genvar s = 0; s < NW; s++) begin : g_step
    logic [LANES-1:0][NW-1:0] p_num;
    logic [LANES-1:0][NW-1:0] p_quot;
    logic [LANES-1:0][NW-1:0] n_quot;
    logic [LANES-1:0][DW-1:0] p_rem;
    logic [LANES-1:0][DW-1:0] p_den;
    logic [LANES-1:0][DW-1:0] n_rem;
    logic [LANES-1:0][DW:0]   trial;
    logic [SW-1:0]            p_side;
    logic                     p_valid;

    if (s == 0) begin : g_head
      assign p_num   = num;
      assign p_quot  = '0;
      assign p_rem   = '0;
      assign p_den   = den;
      assign p_side  = side_in;
      assign p_valid = in_valid;
    end else begin : g_tail
      assign p_num   = r_num[s-1];
      assign p_quot  = r_quot[s-1];
      assign p_rem   = r_rem[s-1];
      assign p_den   = r_den[s-1];
      assign p_side  = r_side[s-1];
      assign p_valid = r_valid[s-1];
    end

    // bring down the next numerator bit and subtract where it fits
    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        trial[l] = {p_rem[l], p_num[l][NW-1-s]};
        if (trial[l] >= {1'b0, p_den[l]}) begin
          n_rem[l]  = DW'(trial[l] - {1'b0, p_den[l]});
          n_quot[l] = p_quot[l] | (NW'(1) << (NW - 1 - s));
        end else begin
          n_rem[l]  = trial[l][DW-1:0];
          n_quot[l] = p_quot[l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        r_valid[s] <= 1'b0;
      end else if (en) begin
        r_valid[s] <= p_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_num[s]  <= p_num;
        r_quot[s] <= n_quot;
        r_rem[s]  <= n_rem;
        r_den[s]  <= p_den;
        r_side[s] <= p_side;
      end
    end
  end

  assign out_valid = r_valid[NW-1];
  assign quot      = r_quot[NW-1];
  assign side_out  = r_side[NW-1];

endmodule

// ----- design/tfl_back.sv -----
// back end: segment search, knot stores and per-channel interpolation pipeline
`include "transfer_function_lut_interpolator_macros.svh"

module tfl_back import tfl_pkg::*; #(
  parameter int TABLE_SIZE = 1024,
  parameter int MAX_KNOTS  = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  queue_item_t pop_item,
  input  logic [6:0]  color_knot_count,
  input  logic [6:0]  opacity_knot_count,
  output logic        result_valid,
  input  logic        result_ready,
  output result_t     result
);
  localparam int RW  = $clog2(TABLE_SIZE + 1);
  localparam int KW  = $clog2(MAX_KNOTS);
  localparam int IW  = RW + KW;
  localparam int PW  = 16 + RW;
  localparam int CH  = 5;
  localparam int OPA = 4;   // opacity lane after the four colour lanes
  localparam int LB  = $clog2(TABLE_SIZE);
  localparam int QS  = IW + LB;
  localparam int MW  = IW + 1;
  localparam int XW  = IW + MW;
  localparam logic [MW-1:0] RECIP =
    MW'(((64'd1 << QS) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE));

  typedef struct packed {
    queue_item_t item;
    logic [63:0] knot_a;
    logic [63:0] knot_b;
    logic [15:0] op_a;
    logic [15:0] op_b;
  } seg_side_t;

  typedef struct packed {
    kind_t                kind;
    logic [9:0]           entry;
    logic                 color_ok;
    logic                 opacity_ok;
    logic [CH-1:0][15:0]  base;
    logic [CH-1:0]        neg;
  } lerp_side_t;

  logic            en;
  logic [8:0]      nc;
  logic [8:0]      no;
  logic [KW-1:0]   d_col;
  logic [KW-1:0]   d_opa;

  // whole pipeline moves together, held only by a full output register
  assign en        = !result_valid || result_ready;
  assign pop_ready = en;

  assign nc    = clamp_count(color_knot_count, MAX_KNOTS);
  assign no    = clamp_count(opacity_knot_count, MAX_KNOTS);
  assign d_col = KW'(nc - 9'd1);
  assign d_opa = KW'(no - 9'd1);

  // index numerators: (j+1)*d - 1, divided by the table size
  logic                  s0_valid;
  queue_item_t           s0_item;
  logic [1:0][IW-1:0]    s0_num;
  logic [RW-1:0]         jp1;

  assign jp1 = RW'(pop_item.entry) + RW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_item   <= pop_item;
      s0_num[0] <= IW'(jp1) * IW'(d_col) - IW'(1);
      s0_num[1] <= IW'(jp1) * IW'(d_opa) - IW'(1);
    end
  end

  // segment index by reciprocal multiplication, exact for any numerator of IW bits
  logic                  d1_valid;
  logic [1:0][IW-1:0]    d1_quot;
  queue_item_t           d1_item;
  logic [1:0][XW-1:0]    s0_prod;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      s0_prod[l] = XW'(s0_num[l]) * XW'(RECIP);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d1_valid <= 1'b0;
    end else if (en) begin
      d1_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_item <= s0_item;
      for (int l = 0; l < 2; l++) begin
        d1_quot[l] <= IW'(s0_prod[l] >> QS);
      end
    end
  end

  // knot stores: loads write here so they stay in order with requests
  logic [KW-1:0]   i_col;
  logic [KW-1:0]   i_col_n;
  logic [KW-1:0]   i_opa;
  logic [KW-1:0]   i_opa_n;
  logic [KW-1:0]   kidx;
  logic [63:0]     color_mem   [MAX_KNOTS];
  logic [15:0]     opacity_mem [MAX_KNOTS];
  logic [63:0]     sm_ca;
  logic [63:0]     sm_cb;
  logic [15:0]     sm_oa;
  logic [15:0]     sm_ob;
  logic            sm_valid;
  queue_item_t     sm_item;
  logic [3:0][IW-1:0] sm_num;

  assign i_col   = d1_quot[0][KW-1:0];
  assign i_col_n = i_col + KW'(1);
  assign i_opa   = d1_quot[1][KW-1:0];
  assign i_opa_n = i_opa + KW'(1);
  assign kidx    = KW'(d1_item.knot_index);

  always_ff @(posedge clk) begin
    if (en) begin
      if (d1_valid && d1_item.kind == KIND_COLOR) color_mem[kidx] <= d1_item.color;
      sm_ca <= color_mem[i_col];
      sm_cb <= color_mem[i_col_n];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (d1_valid && d1_item.kind == KIND_OPACITY) opacity_mem[kidx] <= d1_item.opacity;
      sm_oa <= opacity_mem[i_opa];
      sm_ob <= opacity_mem[i_opa_n];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sm_valid <= 1'b0;
    end else if (en) begin
      sm_valid <= d1_valid;
    end
  end

  // segment bounds i*R/d and (i+1)*R/d
  always_ff @(posedge clk) begin
    if (en) begin
      sm_item   <= d1_item;
      sm_num[0] <= IW'(i_col) * IW'(TABLE_SIZE);
      sm_num[1] <= IW'(i_col_n) * IW'(TABLE_SIZE);
      sm_num[2] <= IW'(i_opa) * IW'(TABLE_SIZE);
      sm_num[3] <= IW'(i_opa_n) * IW'(TABLE_SIZE);
    end
  end

  seg_side_t             sm_side;
  logic                  d2_valid;
  logic [3:0][IW-1:0]    d2_quot;
  logic [$bits(seg_side_t)-1:0] d2_side;
  seg_side_t             d2_s;

  assign sm_side = '{item: sm_item, knot_a: sm_ca, knot_b: sm_cb, op_a: sm_oa, op_b: sm_ob};

  tfl_div #(
    .NW(IW), .DW(KW), .LANES(4), .SW($bits(seg_side_t))
  ) u_div_bound (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (sm_valid),
    .num      (sm_num),
    .den      ({d_opa, d_opa, d_col, d_col}),
    .side_in  (sm_side),
    .out_valid(d2_valid),
    .quot     (d2_quot),
    .side_out (d2_side)
  );

  assign d2_s = seg_side_t'(d2_side);

  // offsets, spans and signed knot differences
  logic [RW-1:0]        j_r;
  logic [CH-1:0][15:0]  ka;
  logic [CH-1:0][15:0]  kb;
  logic [CH-1:0][15:0]  mag;
  logic [CH-1:0]        neg;

  always_comb begin
    j_r = RW'(d2_s.item.entry);
    for (int k = 0; k < CH; k++) begin
      if (k == OPA) begin
        ka[k] = d2_s.op_a;
        kb[k] = d2_s.op_b;
      end else begin
        ka[k] = d2_s.knot_a[16*k +: 16];
        kb[k] = d2_s.knot_b[16*k +: 16];
      end
      neg[k] = kb[k] < ka[k];
      mag[k] = neg[k] ? ka[k] - kb[k] : kb[k] - ka[k];
    end
  end

  logic                  sp1_valid;
  lerp_side_t            sp1_side;
  logic [CH-1:0][15:0]   sp1_mag;
  logic [RW-1:0]         sp1_off_c;
  logic [RW-1:0]         sp1_off_o;
  logic [RW-1:0]         sp1_span_c;
  logic [RW-1:0]         sp1_span_o;

  always_ff @(posedge clk) begin
    if (rst) begin
      sp1_valid <= 1'b0;
    end else if (en) begin
      sp1_valid <= d2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sp1_side.kind       <= d2_s.item.kind;
      sp1_side.entry      <= d2_s.item.entry;
      sp1_side.color_ok   <= d2_s.item.color_ok;
      sp1_side.opacity_ok <= d2_s.item.opacity_ok;
      sp1_side.base       <= ka;
      sp1_side.neg        <= neg;
      sp1_mag             <= mag;
      sp1_off_c           <= j_r - RW'(d2_quot[0]);
      sp1_span_c          <= RW'(d2_quot[1]) - RW'(d2_quot[0]);
      sp1_off_o           <= j_r - RW'(d2_quot[2]);
      sp1_span_o          <= RW'(d2_quot[3]) - RW'(d2_quot[2]);
    end
  end

  logic                  sp2_valid;
  lerp_side_t            sp2_side;
  logic [CH-1:0][PW-1:0] sp2_prod;
  logic [RW-1:0]         sp2_span_c;
  logic [RW-1:0]         sp2_span_o;

  always_ff @(posedge clk) begin
    if (rst) begin
      sp2_valid <= 1'b0;
    end else if (en) begin
      sp2_valid <= sp1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sp2_side   <= sp1_side;
      sp2_span_c <= sp1_span_c;
      sp2_span_o <= sp1_span_o;
      for (int k = 0; k < CH; k++) begin
        sp2_prod[k] <= PW'(sp1_mag[k]) * PW'((k == OPA) ? sp1_off_o : sp1_off_c);
      end
    end
  end

  logic                  d3_valid;
  logic [CH-1:0][PW-1:0] d3_quot;
  logic [$bits(lerp_side_t)-1:0] d3_side;
  lerp_side_t            d3_s;

  tfl_div #(
    .NW(PW), .DW(RW), .LANES(CH), .SW($bits(lerp_side_t))
  ) u_div_lerp (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (sp2_valid),
    .num      (sp2_prod),
    .den      ({sp2_span_o, sp2_span_c, sp2_span_c, sp2_span_c, sp2_span_c}),
    .side_in  (sp2_side),
    .out_valid(d3_valid),
    .quot     (d3_quot),
    .side_out (d3_side)
  );

  assign d3_s = lerp_side_t'(d3_side);

  // truncation toward zero: divide the magnitude, then apply the sign
  logic [CH-1:0][15:0] val;
  result_t             res_next;

  always_comb begin
    for (int k = 0; k < CH; k++) begin
      val[k] = d3_s.neg[k] ? d3_s.base[k] - d3_quot[k][15:0]
                           : d3_s.base[k] + d3_quot[k][15:0];
    end
    res_next.entry_number = d3_s.entry;
    res_next.out_red      = d3_s.color_ok ? val[0] : 16'd0;
    res_next.out_green    = d3_s.color_ok ? val[1] : 16'd0;
    res_next.out_blue     = d3_s.color_ok ? val[2] : 16'd0;
    if (d3_s.opacity_ok) begin
      res_next.out_alpha = val[OPA];
    end else begin
      res_next.out_alpha = d3_s.color_ok ? val[3] : 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= d3_valid && d3_s.kind == KIND_REQUEST;
    end
  end

  always_ff @(posedge clk) begin
    if (en) result <= res_next;
  end

  `TFL_ASSERT_IMP(a_col_seg_range, d1_valid && d1_item.kind == KIND_REQUEST && d1_item.color_ok, i_col < d_col, "colour segment past last knot pair")
  `TFL_ASSERT_IMP(a_opa_seg_range, d1_valid && d1_item.kind == KIND_REQUEST && d1_item.opacity_ok, i_opa < d_opa, "opacity segment past last knot pair")
  `TFL_ASSERT_IMP(a_col_span, sp2_valid && sp2_side.kind == KIND_REQUEST && sp2_side.color_ok, sp2_span_c != '0, "empty colour segment selected")
  `TFL_ASSERT_IMP(a_opa_span, sp2_valid && sp2_side.kind == KIND_REQUEST && sp2_side.opacity_ok, sp2_span_o != '0, "empty opacity segment selected")

endmodule
